// ===== sv/pcfd_pkg.sv =====
// shared types and constants for the pwm capture frequency and duty unit
// no dependencies; imported by every module of the block
package pcfd_pkg;

  // fixed field widths
  localparam int unsigned OpBits      = 2;
  localparam int unsigned CountBits   = 16;
  localparam int unsigned FreqBits    = 24;
  localparam int unsigned DutyBits    = 10;
  localparam int unsigned TickBits    = 32;
  localparam int unsigned CounterBits = 16;
  localparam int unsigned DutyScale   = 1000;
  localparam int unsigned NumerBits   = TickBits + DutyBits;
  localparam int unsigned StepBits    = 5;

  // capture clock rate after reset, in hertz
  localparam logic [FreqBits-1:0] ClockReset = 24'd1000000;

  // event codes
  typedef enum logic [OpBits-1:0] {
    OP_OVERFLOW = 2'd0,
    OP_HIGH     = 2'd1,
    OP_PERIOD   = 2'd2
  } op_e;

  // input word
  typedef struct packed {
    logic [OpBits-1:0]    operation;
    logic [CountBits-1:0] captured_count;
  } in_t;

  // output word
  typedef struct packed {
    logic [FreqBits-1:0] frequency;
    logic [DutyBits-1:0] duty_milli;
    logic                updated;
  } out_t;

  // job handed from front to back
  typedef struct packed {
    logic                upd;
    logic [TickBits-1:0] period;
    logic [TickBits-1:0] high_time;
  } job_t;

  // push side of the job queue
  typedef struct packed {
    logic valid;
    job_t job;
  } push_t;

  // pop side of the job queue
  typedef struct packed {
    logic valid;
    job_t job;
  } head_t;

endpackage

// ===== sv/pwm_capture_frequency_duty_unit.sv =====
// top level of the pwm capture frequency and duty unit
// depends on pcfd_pkg, pcfd_front, pcfd_queue, pcfd_back
//
//   channel  dir  handshake              word
//   in       in   in_valid_i/in_ready_o   in_t: operation, captured_count
//   out      out  out_valid_o/out_ready_i out_t: frequency, duty_milli, updated
//   cfg      in   cfg_valid_i/cfg_ready_o capture clock rate, 24 bits
//
// overflow, high capture and period captures that do not refresh pass through the queue
// entry and the output register; a refreshing period capture also runs the shared serial
// divider (24 steps for frequency, then 10 steps for duty).
// a two-entry job queue lets the front keep taking events while the divider runs.
// reset clears the control state and sets the clock rate to 1000000; datapath registers are not reset.
// a stalled output holds its word; the front stalls only when the queue is full.
module pwm_capture_frequency_duty_unit
  import pcfd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_t                 in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_t                out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [FreqBits-1:0] cfg_data_i
);

  logic [FreqBits-1:0] clock_rate_q;
  push_t               push;
  head_t               head;
  logic                q_full;
  logic                pop;

  // clock rate register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clock_rate_q <= ClockReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      clock_rate_q <= cfg_data_i;
    end
  end

  pcfd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .q_full_i   (q_full),
    .push_o     (push)
  );

  pcfd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (q_full),
    .head_o (head),
    .pop_i  (pop)
  );

  pcfd_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .pop_o        (pop),
    .clock_rate_i (clock_rate_q),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_o   (out_data_o)
  );

endmodule

// ===== sv/pcfd_front.sv =====
// front part: accepts timer events, extends ticks and classifies period captures
// depends on pcfd_pkg
module pcfd_front
  import pcfd_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  in_t   in_data_i,
  input  logic  q_full_i,
  output push_t push_o
);

  logic [CountBits-1:0] ovf_q, ovf_d;
  logic [TickBits-1:0]  high_q, high_d;
  logic [63:0]          ext_wide;
  logic [TickBits-1:0]  ext;
  logic                 accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // extended tick value, kept modulo 2^32
  assign ext_wide = (64'(ovf_q) << CounterBits) + 64'(in_data_i.captured_count);
  assign ext      = ext_wide[TickBits-1:0];

  // event decode and job build
  always_comb begin
    ovf_d                 = ovf_q;
    high_d                = high_q;
    push_o.valid          = accept;
    push_o.job.upd        = 1'b0;
    push_o.job.period     = ext;
    push_o.job.high_time  = high_q;
    if (accept) begin
      case (op_e'(in_data_i.operation))
        OP_OVERFLOW: ovf_d  = ovf_q + 1'b1;
        OP_HIGH:     high_d = ext;
        OP_PERIOD: begin
          ovf_d          = '0;
          push_o.job.upd = (ext != '0) && (high_q <= ext);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovf_q  <= '0;
      high_q <= '0;
    end else begin
      ovf_q  <= ovf_d;
      high_q <= high_d;
    end
  end

endmodule

// ===== sv/pcfd_queue.sv =====
// two-entry job queue between the front and the back
// depends on pcfd_pkg
module pcfd_queue
  import pcfd_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  push_t push_i,
  output logic  full_o,
  output head_t head_o,
  input  logic  pop_i
);

  logic [1:0] cnt_q, cnt_d;
  logic       wr_ptr_q, rd_ptr_q;
  job_t       mem_q [2];
  logic       do_push, do_pop;

  assign full_o      = cnt_q[1];
  assign head_o.valid = (cnt_q != 2'd0);
  assign head_o.job   = mem_q[rd_ptr_q];
  assign do_push     = push_i.valid && !full_o;
  assign do_pop      = pop_i && head_o.valid;

  // occupancy
  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.job;
    end
  end

endmodule

// ===== sv/pcfd_back.sv =====
// back part: serial divider for frequency and duty, result register
// depends on pcfd_pkg
module pcfd_back
  import pcfd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  head_t               head_i,
  output logic                pop_o,
  input  logic [FreqBits-1:0] clock_rate_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_t                out_data_o
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_FREQ = 4'b0010,
    ST_DUTY = 4'b0100,
    ST_DONE = 4'b1000
  } state_e;

  state_e               state_q, state_d;
  logic [StepBits-1:0]  step_q, step_d;
  logic [TickBits-1:0]  period_q, period_d;
  logic [NumerBits-1:0] numer_q, numer_d;
  logic [TickBits-1:0]  rem_q, rem_d;
  logic [FreqBits-1:0]  quo_q, quo_d;
  logic [FreqBits-1:0]  freq_q, freq_d;
  logic [DutyBits-1:0]  duty_q, duty_d;
  out_t                 out_q, out_d;
  logic                 out_valid_q, out_valid_d;

  logic [TickBits:0]    rem_shift;
  logic                 ge;
  logic [TickBits-1:0]  rem_sub;
  logic [TickBits-1:0]  rem_next;
  logic [FreqBits-1:0]  quo_next;
  logic                 slot_free;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign slot_free   = !out_valid_q || out_ready_i;

  // one restoring division step, quotient bit shifts in at the bottom
  assign rem_shift = {rem_q, quo_q[FreqBits-1]};
  assign ge        = rem_shift >= {1'b0, period_q};
  assign rem_sub   = rem_shift[TickBits-1:0] - period_q;
  assign rem_next  = ge ? rem_sub : rem_shift[TickBits-1:0];
  assign quo_next  = {quo_q[FreqBits-2:0], ge};

  // sequencer
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    period_d    = period_q;
    numer_d     = numer_q;
    rem_d       = rem_q;
    quo_d       = quo_q;
    freq_d      = freq_q;
    duty_d      = duty_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    pop_o       = 1'b0;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (head_i.valid && slot_free) begin
          pop_o = 1'b1;
          if (head_i.job.upd) begin
            period_d = head_i.job.period;
            numer_d  = NumerBits'(head_i.job.high_time) * NumerBits'(DutyScale);
            quo_d    = clock_rate_i;
            rem_d    = '0;
            step_d   = '0;
            state_d  = ST_FREQ;
          end else begin
            out_d.frequency  = freq_q;
            out_d.duty_milli = duty_q;
            out_d.updated    = 1'b0;
            out_valid_d      = 1'b1;
          end
        end
      end
      ST_FREQ: begin
        rem_d  = rem_next;
        quo_d  = quo_next;
        step_d = step_q + 1'b1;
        if (step_q == StepBits'(FreqBits - 1)) begin
          // duty quotient fits in ten bits, so start from the upper numerator bits
          freq_d  = quo_next;
          rem_d   = numer_q[NumerBits-1:DutyBits];
          quo_d   = {numer_q[DutyBits-1:0], {(FreqBits-DutyBits){1'b0}}};
          step_d  = '0;
          state_d = ST_DUTY;
        end
      end
      ST_DUTY: begin
        rem_d  = rem_next;
        quo_d  = quo_next;
        step_d = step_q + 1'b1;
        if (step_q == StepBits'(DutyBits - 1)) begin
          duty_d  = quo_next[DutyBits-1:0];
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          out_d.frequency  = freq_q;
          out_d.duty_milli = duty_q;
          out_d.updated    = 1'b1;
          out_valid_d      = 1'b1;
          state_d          = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      freq_q      <= '0;
      duty_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      freq_q      <= freq_d;
      duty_q      <= duty_d;
      out_valid_q <= out_valid_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    period_q <= period_d;
    numer_q  <= numer_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
    out_q    <= out_d;
  end

endmodule

// ===== sv/pcfd_checker.sv =====
// port-level checks for the pwm capture frequency and duty unit, with bind
// depends on pcfd_pkg and pwm_capture_frequency_duty_unit
module pcfd_checker
  import pcfd_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input in_t                 in_data_i,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input out_t                out_data_o,
  input logic                cfg_valid_i,
  input logic                cfg_ready_o,
  input logic [FreqBits-1:0] cfg_data_i
);

  logic [FreqBits-1:0] rate_q;

  // mirror of the clock rate seen on the config port
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= ClockReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      rate_q <= cfg_data_i;
    end
  end

  // stalled input word stays offered and unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_ready_o |=> in_valid_i && $stable(in_data_i))
    else $error("input word dropped or changed while stalled");

  // stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("output valid dropped while stalled");

  // stalled result keeps its word
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_data_o))
    else $error("output word changed while stalled");

  // duty never exceeds full scale
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.duty_milli <= DutyBits'(DutyScale))
    else $error("duty above 1000 per mille");

  // refreshed frequency cannot exceed the clock rate
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.updated |-> out_data_o.frequency <= rate_q)
    else $error("frequency above capture clock rate");

endmodule

bind pwm_capture_frequency_duty_unit pcfd_checker u_checker (.*);
